FILE: design/dsc_pkg.sv
`timescale 1ns / 1ps
package dsc_pkg;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 9;
   localparam int COLS_REG_W  = 9;
   localparam int ROWS_REG_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMNS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS    = 1'd1;

   localparam int COLUMNS_RESET = 80;
   localparam int ROWS_RESET    = 24;

   localparam int MAX_COLUMNS_DEFAULT = 256;
   localparam int MAX_ROWS_DEFAULT    = 128;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Input operations
   localparam logic OP_CELL  = 1'b0;
   localparam logic OP_FRAME = 1'b1;

   // Result kinds
   localparam logic KIND_SCROLL = 1'b0;
   localparam logic KIND_SPAN   = 1'b1;

   typedef struct packed {
      logic              operation;
      logic              cell_dirty;
      logic              row_writable;
      logic signed [7:0] frame_scroll;
   } req_type;

   typedef struct packed {
      logic              op_kind;
      logic        [6:0] span_row;
      logic        [7:0] span_column;
      logic        [8:0] span_width;
      logic signed [7:0] scroll_amount;
      logic        [6:0] bottom_row;
      logic              last_of_run;
   } rsp_type;

   // All the words caused by one input item; pair marks that second is used.
   typedef struct packed {
      logic    pair;
      rsp_type first;
      rsp_type second;
   } bundle_type;

endpackage

FILE: design/dsc_front.sv
`timescale 1ns / 1ps
module dsc_front #(
   parameter int MAX_COLUMNS = dsc_pkg::MAX_COLUMNS_DEFAULT,
   parameter int MAX_ROWS    = dsc_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [dsc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dsc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             accept,
   input  dsc_pkg::req_type                 req_data,
   output logic                             push,
   output dsc_pkg::bundle_type              push_data
);
   import dsc_pkg::*;

   localparam int COL_W  = $clog2(MAX_COLUMNS);
   localparam int ECOL_W = $clog2(MAX_COLUMNS + 1);
   localparam int ROW_W  = $clog2(MAX_ROWS + 1);

   localparam logic [ECOL_W-1:0] COLS_AT_RESET =
      ECOL_W'(COLUMNS_RESET > MAX_COLUMNS ? MAX_COLUMNS : COLUMNS_RESET);
   localparam logic [ROW_W-1:0] ROWS_AT_RESET =
      ROW_W'(ROWS_RESET > MAX_ROWS ? MAX_ROWS : ROWS_RESET);

   logic [ECOL_W-1:0] cols_ff, cols_in;
   logic [ROW_W-1:0]  rows_ff, rows_in;
   logic [COLS_REG_W-1:0] col_value;
   logic [ROWS_REG_W-1:0] row_value;

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              run_open_ff, run_open_in;
   logic [COL_W-1:0]  run_start_ff, run_start_in;
   logic              held_valid_ff, held_valid_in;
   logic [COL_W-1:0]  held_col_ff, held_col_in;
   logic [ECOL_W-1:0] held_width_ff, held_width_in;

   logic              is_frame, active, dirty, row_end, close, merge;
   logic              emit_a, emit_b, emit_c;
   logic              held_v1;
   logic [COL_W-1:0]  held_col1, run_start1;
   logic [ECOL_W-1:0] held_w1, col_plus1, run_tail_w;
   logic [ECOL_W:0]   held_reach;
   rsp_type           word_a, word_b, word_c, word_scroll;

   function automatic rsp_type span_word(input logic [ROW_W-1:0]  row,
                                         input logic [COL_W-1:0]  col,
                                         input logic [ECOL_W-1:0] width);
      rsp_type w;
      w             = '0;
      w.op_kind     = KIND_SPAN;
      w.span_row    = 7'(row);
      w.span_column = 8'(col);
      w.span_width  = 9'(width);
      return w;
   endfunction

   // Counts are clamped when written, so the scan only ever sees legal values.
   assign col_value = csr_wdata[COLS_REG_W-1:0];
   assign row_value = csr_wdata[ROWS_REG_W-1:0];

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_COLUMNS: begin
               if (col_value == '0) cols_in = ECOL_W'(1);
               else if (int'(col_value) > MAX_COLUMNS) cols_in = ECOL_W'(MAX_COLUMNS);
               else cols_in = ECOL_W'(col_value);
            end
            CSR_ROWS: begin
               if (row_value == '0) rows_in = ROW_W'(1);
               else if (int'(row_value) > MAX_ROWS) rows_in = ROW_W'(MAX_ROWS);
               else rows_in = ROW_W'(row_value);
            end
            default: begin
               cols_in = cols_ff;
               rows_in = rows_ff;
            end
         endcase
      end
   end

   // Classification of the current cell.
   assign is_frame   = (req_data.operation == OP_FRAME);
   assign active     = (row_ff < rows_ff);
   assign dirty      = req_data.cell_dirty & req_data.row_writable;
   assign col_plus1  = ECOL_W'(col_ff) + ECOL_W'(1);
   assign row_end    = (col_plus1 >= cols_ff);
   assign close      = !dirty && run_open_ff;
   assign held_reach = (ECOL_W+1)'(held_col_ff) + (ECOL_W+1)'(held_width_ff)
                       + (ECOL_W+1)'(1);
   assign merge      = close && held_valid_ff && ((ECOL_W+1)'(run_start_ff) <= held_reach);
   assign emit_a     = close && held_valid_ff && !merge;

   assign held_v1    = held_valid_ff || close;
   assign held_col1  = (close && !merge) ? run_start_ff : held_col_ff;
   assign held_w1    = !close ? held_width_ff :
                       merge  ? ECOL_W'(col_ff) - ECOL_W'(held_col_ff) :
                                ECOL_W'(col_ff) - ECOL_W'(run_start_ff);
   assign run_start1 = (dirty && !run_open_ff) ? col_ff : run_start_ff;
   assign run_tail_w = col_plus1 - ECOL_W'(run_start1);

   // At the row end the held span goes first, then a run reaching the edge.
   assign emit_b = row_end && held_v1;
   assign emit_c = row_end && dirty;

   assign word_a = span_word(row_ff, held_col_ff, held_width_ff);
   assign word_b = span_word(row_ff, held_col1, held_w1);
   assign word_c = span_word(row_ff, run_start1, run_tail_w);

   always_comb begin
      word_scroll               = '0;
      word_scroll.op_kind       = KIND_SCROLL;
      word_scroll.scroll_amount = req_data.frame_scroll;
      word_scroll.bottom_row    = 7'(rows_ff - ROW_W'(1));
   end

   always_comb begin
      push      = 1'b0;
      push_data = '0;
      if (accept) begin
         if (is_frame) begin
            push                       = (req_data.frame_scroll != '0);
            push_data.first            = word_scroll;
            push_data.first.last_of_run = 1'b1;
         end else if (active) begin
            push = emit_a || emit_b || emit_c;
            if (emit_a) begin
               push_data.first = word_a;
               if (emit_b) begin
                  push_data.pair               = 1'b1;
                  push_data.second             = word_b;
                  push_data.second.last_of_run = 1'b1;
               end else begin
                  push_data.first.last_of_run = 1'b1;
               end
            end else if (emit_b) begin
               push_data.first = word_b;
               if (emit_c) begin
                  push_data.pair               = 1'b1;
                  push_data.second             = word_c;
                  push_data.second.last_of_run = 1'b1;
               end else begin
                  push_data.first.last_of_run = 1'b1;
               end
            end else if (emit_c) begin
               push_data.first             = word_c;
               push_data.first.last_of_run = 1'b1;
            end
         end
      end
   end

   always_comb begin
      row_in        = row_ff;
      col_in        = col_ff;
      run_open_in   = run_open_ff;
      run_start_in  = run_start_ff;
      held_valid_in = held_valid_ff;
      held_col_in   = held_col_ff;
      held_width_in = held_width_ff;
      if (accept) begin
         if (is_frame) begin
            row_in        = '0;
            col_in        = '0;
            run_open_in   = 1'b0;
            held_valid_in = 1'b0;
         end else if (active) begin
            if (row_end) begin
               row_in        = row_ff + ROW_W'(1);
               col_in        = '0;
               run_open_in   = 1'b0;
               held_valid_in = 1'b0;
            end else begin
               col_in        = COL_W'(col_plus1);
               run_open_in   = dirty;
               run_start_in  = run_start1;
               held_valid_in = held_v1;
               held_col_in   = held_col1;
               held_width_in = held_w1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff       <= COLS_AT_RESET;
         rows_ff       <= ROWS_AT_RESET;
         row_ff        <= '0;
         col_ff        <= '0;
         run_open_ff   <= 1'b0;
         held_valid_ff <= 1'b0;
      end else begin
         cols_ff       <= cols_in;
         rows_ff       <= rows_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         run_open_ff   <= run_open_in;
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_start_ff  <= run_start_in;
      held_col_ff   <= held_col_in;
      held_width_ff <= held_width_in;
   end

   // A held span always lies strictly left of a run that is still open.
   a_held_before_run: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff && run_open_ff |-> run_start_ff > held_col_ff)
      else $error("open run does not start after the held span");

   a_held_nonempty: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> held_width_ff != '0)
      else $error("held span has zero width");

   // Only span words ever come in pairs.
   a_pair_is_span: assert property (@(posedge clock) disable iff (reset)
      push && push_data.pair |-> push_data.first.op_kind == KIND_SPAN)
      else $error("scroll word paired with another word");

endmodule

FILE: design/dsc_queue.sv
`timescale 1ns / 1ps
module dsc_queue #(
   parameter int DEPTH = dsc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dsc_pkg::bundle_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output dsc_pkg::bundle_type head
);
   import dsc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bundle_type        entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

endmodule

FILE: design/dsc_back.sv
`timescale 1ns / 1ps
module dsc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  dsc_pkg::bundle_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output dsc_pkg::rsp_type    rsp_data
);
   import dsc_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    sel_ff, sel_in;
   logic    load, take;

   // The output register refills whenever its word is gone or being taken.
   assign load = !rsp_valid_ff || !rsp_stall;
   assign take = load && !empty;
   assign pop  = take && (sel_ff || !head.pair);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      sel_in       = sel_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = sel_ff ? head.second : head.first;
         sel_in       = !pop;
      end else if (load) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: design/dirty_span_coalescer.sv
`timescale 1ns / 1ps
// Dirty span coalescer: turns a row-major stream of cell dirty marks into
// scroll and span update words.
// The req_ channel takes one word per clock: either a begin-frame word with
// a scroll delta, or one cell with its dirty mark and row-writable flag. The
// rsp_ channel gives scroll and span words, one per clock, with last_of_run
// set on the final word caused by each input word. Both channels move a word
// when valid is high and stall is low.
// The front scan logic handles one cell per clock and never waits on its own
// state; it places the zero, one or two words of each cell into a four-entry
// queue, and the back end drains that queue through a registered output.
// The first word of an input goes through the queue and the output register.
// Inputs are taken at one per clock while the queue has room; a cell that
// yields two words sends them on rsp_ one after the other, so long bursts of
// such cells run at the output rate of one word per clock.
// When the receiver stalls, the output word holds and the queue fills; once
// it is full, req_stall rises until the back end drains an entry.
// Reset (synchronous) empties the queue and output register, returns the
// scan to row 0, column 0, and sets 80 columns and 24 rows. The user must
// write csr_ column and row counts only while idle; the block does not check.
module dirty_span_coalescer #(
   parameter int MAX_COLUMNS = dsc_pkg::MAX_COLUMNS_DEFAULT,
   parameter int MAX_ROWS    = dsc_pkg::MAX_ROWS_DEFAULT,
   parameter int QUEUE_DEPTH = dsc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  dsc_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output dsc_pkg::rsp_type                rsp_data,
   input  logic                            csr_write,
   input  logic [dsc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dsc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dsc_pkg::*;

   logic       accept;
   logic       push, pop, full, empty;
   bundle_type push_data, head;

   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   dsc_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data)
   );

   dsc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (full),
      .empty     (empty),
      .head      (head)
   );

   dsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
module tb;
   import dsc_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_COLUMNS;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   dirty_span_coalescer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shared run control.
   int errors    = 0;
   bit quiet     = 1'b0;
   int hold_left = 0;

   // Predicted copy of the registers and the scan state.
   logic [8:0] cfg_columns = 9'(COLUMNS_RESET);
   logic [7:0] cfg_rows    = 8'(ROWS_RESET);
   // One bit wider than the row field, as the scan counts past the last row.
   logic [7:0] scan_row    = '0;
   logic [7:0] scan_col    = '0;
   logic       run_active  = 1'b0;
   logic [7:0] run_first   = '0;
   logic       held_active = 1'b0;
   logic [7:0] held_col    = '0;
   logic [8:0] held_len    = '0;

   rsp_type ops_due [$];

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int columns_now();
      if (cfg_columns == 0) return 1;
      if (cfg_columns > MAX_COLUMNS_DEFAULT) return MAX_COLUMNS_DEFAULT;
      return int'(cfg_columns);
   endfunction

   function automatic int rows_now();
      if (cfg_rows == 0) return 1;
      if (cfg_rows > MAX_ROWS_DEFAULT) return MAX_ROWS_DEFAULT;
      return int'(cfg_rows);
   endfunction

   function automatic rsp_type make_op(logic kind, int row, int col, int width,
                                       logic signed [7:0] amount, int bottom);
      rsp_type op;
      op.op_kind       = kind;
      op.span_row      = 7'(row);
      op.span_column   = 8'(col);
      op.span_width    = 9'(width);
      op.scroll_amount = amount;
      op.bottom_row    = 7'(bottom);
      op.last_of_run   = 1'b0;
      return op;
   endfunction

   // Works out the update words that one accepted input word causes.
   function automatic void predict_update_ops(req_type w);
      rsp_type made [2];
      int      n;
      int      cols;
      int      rows;
      int      col;
      int      len;
      logic    dirty;
      logic    row_end;
      n    = 0;
      cols = columns_now();
      rows = rows_now();
      if (w.operation == OP_FRAME) begin
         scan_row    = '0;
         scan_col    = '0;
         run_active  = 1'b0;
         run_first   = '0;
         held_active = 1'b0;
         held_col    = '0;
         held_len    = '0;
         if (w.frame_scroll != 0) begin
            made[n] = make_op(KIND_SCROLL, 0, 0, 0, w.frame_scroll, rows - 1);
            n++;
         end
      end else if (int'(scan_row) < rows) begin
         dirty   = w.cell_dirty && w.row_writable;
         col     = int'(scan_col);
         row_end = (col + 1 >= cols);
         if (dirty) begin
            if (!run_active) begin
               run_active = 1'b1;
               run_first  = 8'(col);
            end
         end else if (run_active) begin
            len = col - int'(run_first);
            if (held_active && int'(run_first) <= int'(held_col) + int'(held_len) + 1) begin
               held_len = 9'(int'(run_first) + len - int'(held_col));
            end else begin
               if (held_active) begin
                  made[n] = make_op(KIND_SPAN, scan_row, held_col, held_len, 8'sd0, 0);
                  n++;
               end
               held_active = 1'b1;
               held_col    = run_first;
               held_len    = 9'(len);
            end
            run_active = 1'b0;
         end
         if (row_end) begin
            if (held_active) begin
               made[n] = make_op(KIND_SPAN, scan_row, held_col, held_len, 8'sd0, 0);
               n++;
               held_active = 1'b0;
            end
            if (run_active) begin
               made[n] = make_op(KIND_SPAN, scan_row, run_first,
                                 col + 1 - int'(run_first), 8'sd0, 0);
               n++;
               run_active = 1'b0;
            end
            scan_col = '0;
            scan_row = scan_row + 1'b1;
         end else begin
            scan_col = 8'(col + 1);
         end
      end
      if (n > 0) made[n-1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) ops_due.push_back(made[i]);
   endfunction

   function automatic void compare_field(string name, logic signed [31:0] want,
                                         logic signed [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : check_ops
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (ops_due.size() == 0) begin
            $display("%0t: word with none expected, expected nothing, got %p", $time, rsp_data);
            errors++;
         end else begin
            want = ops_due.pop_front();
            compare_field("op_kind", want.op_kind, rsp_data.op_kind);
            compare_field("span_row", want.span_row, rsp_data.span_row);
            compare_field("span_column", want.span_column, rsp_data.span_column);
            compare_field("span_width", want.span_width, rsp_data.span_width);
            compare_field("scroll_amount", want.scroll_amount, rsp_data.scroll_amount);
            compare_field("bottom_row", want.bottom_row, rsp_data.bottom_row);
            compare_field("last_of_run", want.last_of_run, rsp_data.last_of_run);
         end
      end
   end

   // Receiver: random stalls, a counted hold-off when asked, none while quiet.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 23);
         end
      end
   end

   function automatic req_type frame_word(logic signed [7:0] delta);
      req_type w;
      w.operation    = OP_FRAME;
      w.cell_dirty   = 1'($urandom_range(1));
      w.row_writable = 1'($urandom_range(1));
      w.frame_scroll = delta;
      return w;
   endfunction

   function automatic req_type cell_word(logic dirty, logic writable);
      req_type w;
      w.operation    = OP_CELL;
      w.cell_dirty   = dirty;
      w.row_writable = writable;
      w.frame_scroll = 8'($urandom_range(255));
      return w;
   endfunction

   task automatic send_word(input req_type w);
      while (!quiet && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_update_ops(w);
   endtask

   // Sends n cells; bit i of each mask belongs to the i-th cell.
   task automatic send_row(input logic [7:0] dirty, input logic [7:0] writable, input int n);
      for (int i = 0; i < n; i++) send_word(cell_word(dirty[i], writable[i]));
   endtask

   task automatic wait_for_ops();
      req_valid <= 1'b0;
      while (ops_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_geometry(input int cols, input int rows);
      wait_for_ops();
      // A cell that causes no word may still be in flight.
      repeat (16) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_COLUMNS;
      csr_wdata <= 9'(cols);
      @(posedge clock);
      csr_index <= CSR_ROWS;
      csr_wdata <= 9'(rows);
      @(posedge clock);
      csr_write   <= 1'b0;
      cfg_columns = 9'(cols);
      cfg_rows    = 8'(rows);
   endtask

   // Cells before any begin-frame, then a frame dropping the open run.
   task automatic test_scan_from_reset();
      send_row(8'b0000_1011, 8'hFF, 4);
      send_word(frame_word(8'sd0));
      send_word(frame_word(8'sd127));
   endtask

   task automatic test_span_merging();
      set_geometry(8, 1);
      send_word(frame_word(-8'sd127));
      // One clean cell between runs merges; a non-writable cell counts as clean.
      send_row(8'b1011_0101, 8'b1110_1111, 8);
      send_word(cell_word(1'b1, 1'b1));
   endtask

   task automatic test_extreme_geometry();
      set_geometry(0, 0);
      send_word(frame_word(8'sd1));
      send_word(cell_word(1'b1, 1'b1));
      send_word(cell_word(1'b1, 1'b1));
      set_geometry(511, 255);
      send_word(frame_word(-8'sd1));
   endtask

   task automatic test_column_lowered();
      set_geometry(6, 2);
      send_word(frame_word(8'sd0));
      send_row(8'b0000_1011, 8'hFF, 4);
      set_geometry(2, 2);
      send_word(cell_word(1'b1, 1'b1));
   endtask

   // Every row of three cells ends with two words, so the queue fills.
   task automatic test_backpressure();
      set_geometry(3, 128);
      send_word(frame_word(8'sd5));
      hold_left = 80;
      repeat (40) send_row(8'b0000_0101, 8'hFF, 3);
      wait_for_ops();
   endtask

   task automatic test_random_frames();
      int counted;
      int phase;
      int cols;
      int rows;
      int total;
      int cells;
      int frames;
      int density;
      int pick;
      logic writable;
      logic signed [7:0] delta;
      counted = 0;
      phase   = 0;
      while (counted < 800) begin
         pick = $urandom_range(99);
         if (phase == 0) begin
            cols = 300;
            rows = 1;
         end else if (phase == 1) begin
            cols = 1;
            rows = 255;
         end else if (pick < 5) begin
            cols = 256;
            rows = 1;
         end else if (pick < 15) begin
            cols = $urandom_range(0, 2);
            rows = $urandom_range(0, 40);
         end else if (pick < 30) begin
            cols = $urandom_range(13, 40);
            rows = $urandom_range(1, 3);
         end else begin
            cols = $urandom_range(2, 12);
            rows = $urandom_range(1, 8);
         end
         set_geometry(cols, rows);
         quiet  = (phase == 3 || phase == 4);
         total  = columns_now() * rows_now();
         frames = (total > 100) ? 1 : $urandom_range(1, 4);
         repeat (frames) begin
            pick  = $urandom_range(99);
            cells = total;
            if (pick < 8) cells = $urandom_range(0, total - 1);
            else if (pick < 16) cells = total + $urandom_range(1, 4);
            delta = ($urandom_range(9) == 0) ? 8'sd0 : 8'($urandom_range(254) - 127);
            send_word(frame_word(delta));
            counted++;
            writable = 1'b1;
            density  = 50;
            for (int i = 0; i < cells; i++) begin
               if (i % columns_now() == 0) begin
                  writable = ($urandom_range(99) < 85);
                  pick     = $urandom_range(99);
                  density  = (pick < 15) ? 0 : (pick < 30) ? 100 : $urandom_range(10, 90);
               end
               send_word(cell_word($urandom_range(99) < density,
                                   ($urandom_range(99) < 3) ? !writable : writable));
               if (i < total) counted++;
            end
         end
         phase++;
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_scan_from_reset();
      test_span_merging();
      test_extreme_geometry();
      test_column_lowered();
      test_backpressure();
      test_random_frames();
      wait_for_ops();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

FILE: dirty_span_coalescer.f
design/dsc_pkg.sv
design/dsc_front.sv
design/dsc_queue.sv
design/dsc_back.sv
design/dirty_span_coalescer.sv
test/tb.sv
